// ----- src/pcf_pkg.sv -----
// Package for the pixel color filter: pixel and configuration types,
// filter mode codes, register indexes and divide-by-three constants.
// No dependencies.
`default_nettype none
package pcf_pkg;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [5:0] mode;
    logic [7:0] strength;
  } cfg_t;

  localparam logic [0:0] CFG_MODE     = 1'd0;
  localparam logic [0:0] CFG_STRENGTH = 1'd1;

  localparam logic [5:0] MODE_RESET    = 6'd0;
  localparam logic [7:0] STRENGTH_RESET = 8'd255;

  // avg = (sum * 683) >> 11, exact for sums up to 765
  localparam logic [9:0] RECIP3    = 10'd683;
  localparam int         AVG_SHIFT = 11;

  localparam logic [5:0] MODE_GREY      = 6'd0;
  localparam logic [5:0] MODE_THRESHOLD = 6'd1;
  localparam logic [5:0] MODE_NEGATIVE  = 6'd2;
  localparam logic [5:0] MODE_SHADOW    = 6'd3;
  localparam logic [5:0] MODE_REP_R     = 6'd4;
  localparam logic [5:0] MODE_REP_G     = 6'd5;
  localparam logic [5:0] MODE_REP_B     = 6'd6;
  localparam logic [5:0] MODE_PASS_R    = 6'd7;
  localparam logic [5:0] MODE_PASS_G    = 6'd8;
  localparam logic [5:0] MODE_PASS_B    = 6'd9;
  localparam logic [5:0] MODE_PASS_M    = 6'd10;
  localparam logic [5:0] MODE_PASS_Y    = 6'd11;
  localparam logic [5:0] MODE_PASS_C    = 6'd12;
  localparam logic [5:0] MODE_FILT_R    = 6'd13;
  localparam logic [5:0] MODE_FILT_G    = 6'd14;
  localparam logic [5:0] MODE_FILT_B    = 6'd15;
  localparam logic [5:0] MODE_ORD_RGB   = 6'd16;
  localparam logic [5:0] MODE_ORD_RBG   = 6'd17;
  localparam logic [5:0] MODE_ORD_GRB   = 6'd18;
  localparam logic [5:0] MODE_ORD_GBR   = 6'd19;
  localparam logic [5:0] MODE_ORD_BRG   = 6'd20;
  localparam logic [5:0] MODE_ORD_BGR   = 6'd21;
  localparam logic [5:0] MODE_BURN_ALL  = 6'd22;
  localparam logic [5:0] MODE_BURN_R    = 6'd23;
  localparam logic [5:0] MODE_BURN_G    = 6'd24;
  localparam logic [5:0] MODE_BURN_B    = 6'd25;
  localparam logic [5:0] MODE_BURN_RG   = 6'd26;
  localparam logic [5:0] MODE_BURN_GB   = 6'd27;
  localparam logic [5:0] MODE_BURN_RB   = 6'd28;
  localparam logic [5:0] MODE_DODGE_ALL = 6'd29;
  localparam logic [5:0] MODE_DODGE_R   = 6'd30;
  localparam logic [5:0] MODE_DODGE_G   = 6'd31;
  localparam logic [5:0] MODE_DODGE_B   = 6'd32;
  localparam logic [5:0] MODE_DODGE_RG  = 6'd33;
  localparam logic [5:0] MODE_DODGE_GB  = 6'd34;
  localparam logic [5:0] MODE_DODGE_RB  = 6'd35;

endpackage
`default_nettype wire

// ----- src/pixel_color_filter_unit.sv -----
// Pixel color filter top level: configuration registers, command
// handshake and the filter datapath. Depends on pcf_pkg and pcf_pipe.
//
// One ARGB pixel enters per clock while busy is low, and its filtered
// pixel leaves through the four register stages of the datapath (input,
// average and hue tests, blend products, divide by 255 and select).
// done marks each result for exactly one cycle and cannot be held off.
// busy is high only in the cycle after reset; otherwise every start is
// taken. Write mode and strength only while no pixel is in flight.
`default_nettype none
module pixel_color_filter_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] alpha_in,
  input  wire logic [7:0] red_in,
  input  wire logic [7:0] green_in,
  input  wire logic [7:0] blue_in,
  output logic            done,
  output logic [7:0]      alpha_out,
  output logic [7:0]      red_out,
  output logic [7:0]      green_out,
  output logic [7:0]      blue_out,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  pcf_pkg::cfg_t   cfg;
  pcf_pkg::pixel_t in_pix;
  pcf_pkg::pixel_t out_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= pcf_pkg::MODE_RESET;
      cfg.strength <= pcf_pkg::STRENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcf_pkg::CFG_MODE:     cfg.mode     <= cfg_data[5:0];
        pcf_pkg::CFG_STRENGTH: cfg.strength <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_pix = '{a: alpha_in, r: red_in, g: green_in, b: blue_in};

  pcf_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_pix    (in_pix),
    .in_cfg    (cfg),
    .out_valid (done),
    .out_pix   (out_pix)
  );

  assign alpha_out = out_pix.a;
  assign red_out   = out_pix.r;
  assign green_out = out_pix.g;
  assign blue_out  = out_pix.b;

endmodule
`default_nettype wire

// ----- src/pcf_pipe.sv -----
// Four-stage filter datapath: input register, average and hue tests,
// blend products with burn and dodge, divide by 255 and mode select.
// Depends on pcf_pkg.
`default_nettype none
module pcf_pipe (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire pcf_pkg::pixel_t in_pix,
  input  wire pcf_pkg::cfg_t   in_cfg,
  output logic               out_valid,
  output pcf_pkg::pixel_t    out_pix
);

  function automatic logic hue_clear(input logic [7:0] x, input logic [7:0] p,
                                     input logic [7:0] q);
    logic [7:0] mx;
    logic [7:0] df;
    mx = (p > q) ? p : q;
    df = (p > q) ? (p - q) : (q - p);
    return (x > p) && (x > q) && ((x - mx) > df);
  endfunction

  function automatic logic pair_clear(input logic [7:0] p, input logic [7:0] q,
                                      input logic [7:0] t);
    logic [7:0] mx;
    logic [7:0] mn;
    logic signed [9:0] lhs;
    logic signed [9:0] rhs;
    mx  = (p > q) ? p : q;
    mn  = (p > q) ? q : p;
    lhs = $signed({2'b00, 8'(mx - mn)});
    rhs = $signed({2'b00, mn}) - $signed({2'b00, t});
    return lhs < rhs;
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // stage A: input register
  logic            va;
  pcf_pkg::pixel_t pa;
  pcf_pkg::cfg_t   ca;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    pa <= in_pix;
    ca <= in_cfg;
  end

  // stage B: average and hue tests
  logic [9:0]  sum_a;
  logic [19:0] avg_prod;
  logic [7:0]  avg_a;
  logic        grey_a;

  assign sum_a    = 10'(pa.r) + 10'(pa.g) + 10'(pa.b);
  assign avg_prod = 20'(sum_a) * 20'(pcf_pkg::RECIP3);
  assign avg_a    = avg_prod[pcf_pkg::AVG_SHIFT +: 8];

  always_comb begin
    unique case (ca.mode)
      pcf_pkg::MODE_PASS_R: grey_a = !hue_clear(pa.r, pa.g, pa.b);
      pcf_pkg::MODE_PASS_G: grey_a = !hue_clear(pa.g, pa.r, pa.b);
      pcf_pkg::MODE_PASS_B: grey_a = !hue_clear(pa.b, pa.r, pa.g);
      pcf_pkg::MODE_PASS_M: grey_a = !pair_clear(pa.r, pa.b, pa.g);
      pcf_pkg::MODE_PASS_Y: grey_a = !pair_clear(pa.r, pa.g, pa.b);
      pcf_pkg::MODE_PASS_C: grey_a = !pair_clear(pa.g, pa.b, pa.r);
      pcf_pkg::MODE_FILT_R: grey_a = (pa.r > pa.g) && (pa.r > pa.b);
      pcf_pkg::MODE_FILT_G: grey_a = (pa.g > pa.b) && (pa.g > pa.r);
      pcf_pkg::MODE_FILT_B: grey_a = (pa.b > pa.r) && (pa.b > pa.g);
      default:              grey_a = 1'b0;
    endcase
  end

  logic            vb;
  pcf_pkg::pixel_t pb;
  pcf_pkg::cfg_t   cb;
  logic [7:0]      avg_b;
  logic            grey_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    pb     <= pa;
    cb     <= ca;
    avg_b  <= avg_a;
    grey_b <= grey_a;
  end

  // stage C: blend products, burn, dodge, threshold compare
  logic [7:0]   w_inv;
  logic [15:0]  s_avg;
  logic [16:0]  mix_r_b;
  logic [16:0]  mix_g_b;
  logic [16:0]  mix_b_b;
  pcf_pkg::rgb_t burn_b;
  pcf_pkg::rgb_t dodge_b;
  logic [8:0]   dsum_r;
  logic [8:0]   dsum_g;
  logic [8:0]   dsum_b;

  assign w_inv   = ~cb.strength;
  assign s_avg   = 16'(cb.strength) * 16'(avg_b);
  assign mix_r_b = 17'(16'(w_inv) * 16'(pb.r)) + 17'(s_avg);
  assign mix_g_b = 17'(16'(w_inv) * 16'(pb.g)) + 17'(s_avg);
  assign mix_b_b = 17'(16'(w_inv) * 16'(pb.b)) + 17'(s_avg);

  assign burn_b.r = (pb.r > cb.strength) ? (pb.r - cb.strength) : 8'd0;
  assign burn_b.g = (pb.g > cb.strength) ? (pb.g - cb.strength) : 8'd0;
  assign burn_b.b = (pb.b > cb.strength) ? (pb.b - cb.strength) : 8'd0;

  assign dsum_r    = 9'(pb.r) + 9'(cb.strength);
  assign dsum_g    = 9'(pb.g) + 9'(cb.strength);
  assign dsum_b    = 9'(pb.b) + 9'(cb.strength);
  assign dodge_b.r = dsum_r[8] ? 8'hFF : dsum_r[7:0];
  assign dodge_b.g = dsum_g[8] ? 8'hFF : dsum_g[7:0];
  assign dodge_b.b = dsum_b[8] ? 8'hFF : dsum_b[7:0];

  logic            vc;
  pcf_pkg::pixel_t pc;
  pcf_pkg::cfg_t   cc;
  logic [7:0]      avg_c;
  logic            grey_c;
  logic            bright_c;
  logic [15:0]     mix_r_c;
  logic [15:0]     mix_g_c;
  logic [15:0]     mix_b_c;
  pcf_pkg::rgb_t   burn_c;
  pcf_pkg::rgb_t   dodge_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    pc       <= pb;
    cc       <= cb;
    avg_c    <= avg_b;
    grey_c   <= grey_b;
    bright_c <= avg_b > cb.strength;
    mix_r_c  <= mix_r_b[15:0];
    mix_g_c  <= mix_g_b[15:0];
    mix_b_c  <= mix_b_b[15:0];
    burn_c   <= burn_b;
    dodge_c  <= dodge_b;
  end

  // stage D: divide, select, output register
  pcf_pkg::rgb_t res;
  logic [7:0]    thr;

  assign thr = bright_c ? 8'hFF : 8'h00;

  always_comb begin
    res = '{r: pc.r, g: pc.g, b: pc.b};
    unique case (cc.mode)
      pcf_pkg::MODE_GREY:      res = '{r: div255(mix_r_c), g: div255(mix_g_c),
                                       b: div255(mix_b_c)};
      pcf_pkg::MODE_THRESHOLD: res = '{r: thr, g: thr, b: thr};
      pcf_pkg::MODE_NEGATIVE:  res = '{r: ~pc.r, g: ~pc.g, b: ~pc.b};
      pcf_pkg::MODE_SHADOW: begin
        if (!bright_c) begin
          res = '0;
        end
      end
      pcf_pkg::MODE_REP_R:     res = '{r: pc.r, g: pc.r, b: pc.r};
      pcf_pkg::MODE_REP_G:     res = '{r: pc.g, g: pc.g, b: pc.g};
      pcf_pkg::MODE_REP_B:     res = '{r: pc.b, g: pc.b, b: pc.b};
      pcf_pkg::MODE_ORD_RBG:   res = '{r: pc.r, g: pc.b, b: pc.g};
      pcf_pkg::MODE_ORD_GRB:   res = '{r: pc.g, g: pc.r, b: pc.b};
      pcf_pkg::MODE_ORD_GBR:   res = '{r: pc.g, g: pc.b, b: pc.r};
      pcf_pkg::MODE_ORD_BRG:   res = '{r: pc.b, g: pc.r, b: pc.g};
      pcf_pkg::MODE_ORD_BGR:   res = '{r: pc.b, g: pc.g, b: pc.r};
      pcf_pkg::MODE_BURN_ALL:  res = burn_c;
      pcf_pkg::MODE_BURN_R:    res.r = burn_c.r;
      pcf_pkg::MODE_BURN_G:    res.g = burn_c.g;
      pcf_pkg::MODE_BURN_B:    res.b = burn_c.b;
      pcf_pkg::MODE_BURN_RG:   res = '{r: burn_c.r, g: burn_c.g, b: pc.b};
      pcf_pkg::MODE_BURN_GB:   res = '{r: pc.r, g: burn_c.g, b: burn_c.b};
      pcf_pkg::MODE_BURN_RB:   res = '{r: burn_c.r, g: pc.g, b: burn_c.b};
      pcf_pkg::MODE_DODGE_ALL: res = dodge_c;
      pcf_pkg::MODE_DODGE_R:   res.r = dodge_c.r;
      pcf_pkg::MODE_DODGE_G:   res.g = dodge_c.g;
      pcf_pkg::MODE_DODGE_B:   res.b = dodge_c.b;
      pcf_pkg::MODE_DODGE_RG:  res = '{r: dodge_c.r, g: dodge_c.g, b: pc.b};
      pcf_pkg::MODE_DODGE_GB:  res = '{r: pc.r, g: dodge_c.g, b: dodge_c.b};
      pcf_pkg::MODE_DODGE_RB:  res = '{r: dodge_c.r, g: pc.g, b: dodge_c.b};
      default: ;
    endcase
    if (grey_c) begin
      res = '{r: avg_c, g: avg_c, b: avg_c};
    end
    if (pc.a == 8'd0) begin
      res = '{r: pc.r, g: pc.g, b: pc.b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vc;
    end
    out_pix <= '{a: pc.a, r: res.r, g: res.g, b: res.b};
  end

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, 4))
    else $error("result without an item four cycles earlier");

  a_alpha_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_pix.a == $past(in_pix.a, 4))
    else $error("alpha not carried with its item");

  a_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pix.a == 8'd0 |->
      out_pix.r == $past(in_pix.r, 4) && out_pix.g == $past(in_pix.g, 4) &&
      out_pix.b == $past(in_pix.b, 4))
    else $error("zero-alpha pixel altered");

  a_negative: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(in_cfg.mode == pcf_pkg::MODE_NEGATIVE, 4) &&
      out_pix.a != 8'd0 |-> out_pix.r == ~$past(in_pix.r, 4))
    else $error("negative mode mismatch on red");
`endif

endmodule
`default_nettype wire
